@@ rtl/twst_pkg.sv @@
// Shared types and constants for the thruster window self-test unit.
package twst_pkg;

  localparam int unsigned NUM_CH         = 6;
  localparam int unsigned MEAS_W_DEFAULT = 16;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned STEP_W         = 8;
  localparam int unsigned LIMIT_W        = 16;
  localparam int unsigned LEVEL_W        = 7;
  localparam int unsigned DRIVE_W        = 8;
  localparam int unsigned CODE_W         = 8;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STEP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL = 2'd3;

  localparam logic [STEP_W-1:0]  STEP_RESET  = 8'd6;
  localparam logic [LIMIT_W-1:0] LOWER_RESET = 16'd25;
  localparam logic [LIMIT_W-1:0] UPPER_RESET = 16'd35;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 7'd30;

  // result slot codes
  localparam logic [1:0] SLOT_FAIL = 2'b01;
  localparam logic [1:0] SLOT_PASS = 2'b10;

  typedef struct packed {
    logic [STEP_W-1:0]  step_seconds;
    logic [LIMIT_W-1:0] lower_limit;
    logic [LIMIT_W-1:0] upper_limit;
    logic [LEVEL_W-1:0] test_level;
  } cfg_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_command;
    logic                      test_active;
    logic [CODE_W-1:0]         result_code;
  } result_t;

endpackage

@@ rtl/twst_lane.sv @@
// One channel lane: absolute speed and window check against the limits.
module twst_lane
  import twst_pkg::*;
#(
  parameter int unsigned MEAS_WIDTH = MEAS_W_DEFAULT
) (
  input  logic signed [MEAS_WIDTH-1:0] measured_i,
  input  logic        [LIMIT_W-1:0]    lower_limit_i,
  input  logic        [LIMIT_W-1:0]    upper_limit_i,
  output logic                         fail_o
);

  localparam int unsigned CMP_W = (MEAS_WIDTH > LIMIT_W) ? MEAS_WIDTH : LIMIT_W;

  logic [MEAS_WIDTH-1:0] mag;
  logic [CMP_W-1:0]      mag_ext;
  logic [CMP_W-1:0]      lower_ext;
  logic [CMP_W-1:0]      upper_ext;

  // most negative value maps to 2^(W-1), which still fits unsigned
  assign mag       = measured_i[MEAS_WIDTH-1] ? (~measured_i + 1'b1) : measured_i;
  assign mag_ext   = CMP_W'(mag);
  assign lower_ext = CMP_W'(lower_limit_i);
  assign upper_ext = CMP_W'(upper_limit_i);

  assign fail_o = (mag_ext < lower_ext) || (mag_ext > upper_ext);

endmodule

@@ rtl/twst_seq.sv @@
// Test sequencer: merges lane fail flags, advances stages, packs result code.
module twst_seq
  import twst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              start_request_i,
  input  logic [TIME_W-1:0] now_seconds_i,
  input  logic [NUM_CH-1:0] lane_fail_i,
  input  cfg_t              cfg_i,
  output result_t           result_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_POS  = 2'd1,
    ST_NEG  = 2'd2
  } stage_e;

  stage_e              stage_q, stage_d;
  logic [TIME_W-1:0]   start_q, start_d;
  logic [NUM_CH-1:0]   fail_q, fail_d;
  logic [DRIVE_W-1:0]  drive_q, drive_d;
  logic [TIME_W-1:0]   elapsed;
  logic                active;
  logic [CODE_W-1:0]   code;
  logic [DRIVE_W-1:0]  level_pos;
  logic [DRIVE_W-1:0]  level_neg;

  assign level_pos = DRIVE_W'(cfg_i.test_level);
  assign level_neg = ~level_pos + 1'b1;

  always_comb begin
    stage_d = stage_q;
    start_d = start_q;
    fail_d  = fail_q;
    drive_d = drive_q;
    active  = start_request_i;
    code    = '0;

    if (!start_request_i) begin
      stage_d = ST_IDLE;
    end

    if (start_request_i && stage_d != ST_POS && stage_d != ST_NEG) begin
      start_d = now_seconds_i;
      drive_d = level_pos;
      fail_d  = '0;
      stage_d = ST_POS;
    end

    elapsed = now_seconds_i - start_d;

    if (stage_d == ST_POS && elapsed >= TIME_W'(cfg_i.step_seconds)) begin
      fail_d  = fail_d | lane_fail_i;
      drive_d = level_neg;
      stage_d = ST_NEG;
    end

    // stages may fall through within one request
    if (stage_d == ST_NEG && elapsed >= TIME_W'({cfg_i.step_seconds, 1'b0})) begin
      fail_d  = fail_d | lane_fail_i;
      drive_d = '0;
      stage_d = ST_IDLE;
      active  = 1'b0;
      // channels 4 and 5 fold onto slots 2 and 3
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (ch < 4) begin
          code[2*ch +: 2] = code[2*ch +: 2] | (fail_d[ch] ? SLOT_FAIL : SLOT_PASS);
        end else begin
          code[2*(ch-2) +: 2] = code[2*(ch-2) +: 2] |
                                (fail_d[ch] ? SLOT_FAIL : SLOT_PASS);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= ST_IDLE;
      start_q <= '0;
      fail_q  <= '0;
      drive_q <= '0;
    end else if (accept_i) begin
      stage_q <= stage_d;
      start_q <= start_d;
      fail_q  <= fail_d;
      drive_q <= drive_d;
    end
  end

  assign result_o.drive_command = drive_d;
  assign result_o.test_active   = active;
  assign result_o.result_code   = code;

endmodule

@@ rtl/thruster_window_self_test_unit.sv @@
// Top level of the thruster window self-test unit: config, lanes, sequencer, output reg.
// Output: the result of an accepted request is on the output register in the next cycle.
// Throughput: one request per cycle while results are read; the output register frees as
//   it is read, so a new request is taken in the same cycle the last result is taken.
// Reset: stage idle, start time, fail bits and drive cleared; registers return to
//   step 6 s, limits 25..35, level 30 %; no result pending.
module thruster_window_self_test_unit
  import twst_pkg::*;
#(
  parameter int unsigned MEAS_WIDTH = MEAS_W_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         start_request_i,
  input  logic [TIME_W-1:0]            now_seconds_i,
  input  logic signed [MEAS_WIDTH-1:0] measured_0_i,
  input  logic signed [MEAS_WIDTH-1:0] measured_1_i,
  input  logic signed [MEAS_WIDTH-1:0] measured_2_i,
  input  logic signed [MEAS_WIDTH-1:0] measured_3_i,
  input  logic signed [MEAS_WIDTH-1:0] measured_4_i,
  input  logic signed [MEAS_WIDTH-1:0] measured_5_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DRIVE_W-1:0]    drive_command_o,
  output logic                         test_active_o,
  output logic [CODE_W-1:0]            result_code_o
);

  cfg_t                         cfg_q;
  logic signed [MEAS_WIDTH-1:0] meas [NUM_CH];
  logic [NUM_CH-1:0]            lane_fail;
  logic                         in_accept;
  result_t                      result;
  result_t                      out_q;
  logic                         out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_seconds <= STEP_RESET;
      cfg_q.lower_limit  <= LOWER_RESET;
      cfg_q.upper_limit  <= UPPER_RESET;
      cfg_q.test_level   <= LEVEL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_STEP:  cfg_q.step_seconds <= cfg_wdata_i[STEP_W-1:0];
        REG_LOWER: cfg_q.lower_limit  <= cfg_wdata_i[LIMIT_W-1:0];
        REG_UPPER: cfg_q.upper_limit  <= cfg_wdata_i[LIMIT_W-1:0];
        REG_LEVEL: cfg_q.test_level   <= cfg_wdata_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign meas[0] = measured_0_i;
  assign meas[1] = measured_1_i;
  assign meas[2] = measured_2_i;
  assign meas[3] = measured_3_i;
  assign meas[4] = measured_4_i;
  assign meas[5] = measured_5_i;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    twst_lane #(
      .MEAS_WIDTH(MEAS_WIDTH)
    ) u_lane (
      .measured_i   (meas[g]),
      .lower_limit_i(cfg_q.lower_limit),
      .upper_limit_i(cfg_q.upper_limit),
      .fail_o       (lane_fail[g])
    );
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  twst_seq u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .start_request_i(start_request_i),
    .now_seconds_i  (now_seconds_i),
    .lane_fail_i    (lane_fail),
    .cfg_i          (cfg_q),
    .result_o       (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= result;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_command_o = out_q.drive_command;
  assign test_active_o   = out_q.test_active;
  assign result_code_o   = out_q.result_code;

endmodule
